// ===== rtl/core/sbmsl_pkg.sv =====
package sbmsl_pkg;

    localparam int SAMPLE_W   = 24;
    localparam int STAGE_W    = 25;
    localparam int FRAC       = 20;
    localparam int THR_W      = 21;
    localparam int COEFF_W    = 20;
    localparam int TANH_DEPTH = 256;
    localparam int TANH_IDX_W = $clog2(TANH_DEPTH);
    localparam int OVER_W     = 23;
    localparam int DIV_STEPS  = OVER_W;

    localparam logic [THR_W-1:0]   THR_MIN       = 21'd10486;
    localparam logic [THR_W-1:0]   THR_MAX       = 21'd1048576;
    localparam logic [COEFF_W-1:0] COEFF_DEFAULT = 20'd17775;
    localparam logic [19:0]        KNEE_Q20      = 20'd964690;

    localparam logic [2:0] REG_MASTER = 3'd0;
    localparam logic [2:0] REG_BASS   = 3'd1;
    localparam logic [2:0] REG_LIM    = 3'd2;
    localparam logic [2:0] REG_THR    = 3'd3;
    localparam logic [2:0] REG_COEFF  = 3'd4;

    typedef struct packed {
        logic               master;
        logic               bass;
        logic               lim;
        logic [THR_W-1:0]   thr;
        logic [COEFF_W-1:0] coeff;
    } cfg_t;

    typedef struct packed {
        logic                      bypass;
        logic                      lim;
        logic signed [STAGE_W-1:0] s_l;
        logic signed [STAGE_W-1:0] s_r;
    } item_t;

    typedef logic [FRAC:0] tanh_rom_t [0:TANH_DEPTH];

    // shift-subtract quotient of a nonnegative value by a positive one
    function automatic longint udiv(input longint n, input longint d);
        longint q;
        longint r;
        q = 0;
        r = 0;
        for (int b = 62; b >= 0; b--) begin
            r = (r <<< 1) | ((n >>> b) & 64'sd1);
            if (r >= d) begin
                r = r - d;
                q = q | (64'sd1 <<< b);
            end
        end
        return q;
    endfunction

    function automatic tanh_rom_t build_tanh_rom();
        tanh_rom_t rom;
        longint    one30;
        longint    y;
        longint    z;
        longint    term;
        longint    sum;
        longint    t;
        longint    den;
        longint    q;
        longint    num;
        longint    dv;
        one30 = 64'sd1 <<< 30;
        for (int i = 0; i <= TANH_DEPTH; i++) begin
            y    = ((64'sd16 <<< 30) * i) >>> TANH_IDX_W;
            z    = y >>> 5;
            term = one30;
            sum  = one30;
            for (int k = 1; k <= 12; k++) begin
                num = term * z;
                dv  = longint'(k) <<< 30;
                if (num < 0) begin
                    term = udiv(-num, dv);
                end else begin
                    term = -udiv(num, dv);
                end
                sum  = sum + term;
            end
            t = sum;
            for (int k = 0; k < 5; k++) begin
                t = (t * t + (one30 >>> 1)) >>> 30;
            end
            den    = one30 + t;
            q      = udiv(((one30 - t) <<< FRAC) + (den >>> 1), den);
            rom[i] = q[FRAC:0];
        end
        return rom;
    endfunction

    localparam tanh_rom_t TANH_ROM = build_tanh_rom();

endpackage

// ===== rtl/core/sbmsl_fifo.sv =====
module sbmsl_fifo (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  sbmsl_pkg::item_t    push_item,
    output logic                full,
    input  logic                pop,
    output sbmsl_pkg::item_t    pop_item,
    output logic                empty
);

    sbmsl_pkg::item_t mem_reg [0:1];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign pop_item = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push && !full) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push && !full) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop && !empty) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + 2'((push && !full) ? 1 : 0) - 2'((pop && !empty) ? 1 : 0);
        end
    end

endmodule

// ===== rtl/core/sbmsl_front.sv =====
module sbmsl_front (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  sbmsl_pkg::cfg_t                       cfg,
    input  logic                                  lp_clear,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [sbmsl_pkg::SAMPLE_W-1:0] s_left_sample,
    input  logic signed [sbmsl_pkg::SAMPLE_W-1:0] s_right_sample,
    output logic                                  q_push,
    output sbmsl_pkg::item_t                      q_item,
    input  logic                                  q_full
);

    localparam int SW = sbmsl_pkg::SAMPLE_W;

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_MUL  = 3'b010,
        F_PUSH = 3'b100
    } fstate_t;

    fstate_t                 state_reg;
    logic signed [SW-1:0]    x_reg  [0:1];
    logic signed [SW-1:0]    lp_reg [0:1];
    logic signed [45:0]      prod_reg [0:1];

    logic [sbmsl_pkg::COEFF_W-1:0] coeff;
    logic signed [SW:0]            diff [0:1];
    logic signed [26:0]            lpn  [0:1];
    logic signed [27:0]            mono;
    logic signed [27:0]            v    [0:1];
    logic signed [sbmsl_pkg::STAGE_W-1:0] s [0:1];

    function automatic logic signed [26:0] in_range27(input logic signed [26:0] val);
        return (val >= -27'sd8388608 && val <= 27'sd8388608) ? val : 27'sd0;
    endfunction

    assign coeff   = (cfg.coeff != '0) ? cfg.coeff : sbmsl_pkg::COEFF_DEFAULT;
    assign s_ready = (state_reg == F_IDLE);

    always_comb begin
        for (int c = 0; c < 2; c++) begin
            diff[c] = (SW+1)'(x_reg[c]) - (SW+1)'(lp_reg[c]);
            lpn[c]  = in_range27(27'(lp_reg[c]) + 27'((prod_reg[c] + 46'sd524288) >>> 20));
        end
        mono = (28'(lpn[0]) + 28'(lpn[1]) + 28'sd1) >>> 1;
        for (int c = 0; c < 2; c++) begin
            v[c] = 28'(x_reg[c]) + mono - 28'(lpn[c]);
            if (cfg.master && cfg.bass) begin
                s[c] = (v[c] >= -28'sd8388608 && v[c] <= 28'sd8388608) ? v[c][24:0] : '0;
            end else begin
                s[c] = 25'(x_reg[c]);
            end
        end
        q_item.bypass = !cfg.master;
        q_item.lim    = cfg.lim;
        q_item.s_l    = s[0];
        q_item.s_r    = s[1];
        q_push        = (state_reg == F_PUSH) && !q_full;
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            x_reg[0] <= s_left_sample;
            x_reg[1] <= s_right_sample;
        end
        if (state_reg == F_MUL) begin
            for (int c = 0; c < 2; c++) begin
                prod_reg[c] <= $signed({1'b0, coeff}) * diff[c];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
            lp_reg[0] <= '0;
            lp_reg[1] <= '0;
        end else begin
            case (state_reg)
                F_IDLE: begin
                    if (s_valid) begin
                        state_reg <= F_MUL;
                    end
                end
                F_MUL: begin
                    state_reg <= F_PUSH;
                end
                F_PUSH: begin
                    if (!q_full) begin
                        state_reg <= F_IDLE;
                        if (cfg.master && cfg.bass) begin
                            lp_reg[0] <= lpn[0][SW-1:0];
                            lp_reg[1] <= lpn[1][SW-1:0];
                        end
                    end
                end
                default: begin
                    state_reg <= F_IDLE;
                end
            endcase
            if (lp_clear) begin
                lp_reg[0] <= '0;
                lp_reg[1] <= '0;
            end
        end
    end

endmodule

// ===== rtl/core/sbmsl_back.sv =====
module sbmsl_back (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  sbmsl_pkg::cfg_t                       cfg,
    input  logic                                  q_empty,
    input  sbmsl_pkg::item_t                      q_item,
    output logic                                  q_pop,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [sbmsl_pkg::SAMPLE_W-1:0] m_left_out,
    output logic signed [sbmsl_pkg::SAMPLE_W-1:0] m_right_out
);

    localparam int SW  = sbmsl_pkg::SAMPLE_W;
    localparam int TW  = sbmsl_pkg::THR_W;
    localparam int OW  = sbmsl_pkg::OVER_W;
    localparam int IW  = sbmsl_pkg::TANH_IDX_W;
    localparam int FR  = sbmsl_pkg::FRAC;
    localparam int DIV_LAST = sbmsl_pkg::DIV_STEPS - 1;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_DIV    = 5'b00010,
        S_INTERP = 5'b00100,
        S_TH     = 5'b01000,
        S_FIN    = 5'b10000
    } bstate_t;

    bstate_t                 state_reg;
    logic [TW-1:0]           knee_reg;
    logic [TW-1:0]           span_reg;
    logic                    bypass_reg;
    logic signed [24:0]      s_reg      [0:1];
    logic                    active_reg [0:1];
    logic                    sat_reg    [0:1];
    logic [43:0]             rem_reg    [0:1];
    logic [OW-1:0]           quo_reg    [0:1];
    logic [42:0]             div_reg;
    logic [4:0]              cnt_reg;
    logic [FR:0]             lo_reg     [0:1];
    logic signed [42:0]      prod_reg   [0:1];
    logic [41:0]             m2_reg     [0:1];
    logic                    m_valid_reg;
    logic signed [SW-1:0]    out_reg    [0:1];

    logic [TW-1:0]           g;
    logic [40:0]             kprod;
    logic signed [24:0]      s_in   [0:1];
    logic [23:0]             mag    [0:1];
    logic [23:0]             diff   [0:1];
    logic                    act    [0:1];
    logic                    sat    [0:1];
    logic [IW-1:0]           idx    [0:1];
    logic [FR-1:0]           fr     [0:1];
    logic [FR:0]             lo     [0:1];
    logic [FR:0]             hi     [0:1];
    logic signed [21:0]      dl     [0:1];
    logic [FR:0]             th     [0:1];
    logic [21:0]             shaped [0:1];
    logic signed [25:0]      val    [0:1];
    logic signed [SW-1:0]    res    [0:1];
    logic                    out_free;

    function automatic logic signed [SW-1:0] clip1(input logic signed [25:0] x);
        if (x > 26'sd1048576) begin
            return SW'(26'sd1048576);
        end else if (x < -26'sd1048576) begin
            return SW'(-26'sd1048576);
        end
        return x[SW-1:0];
    endfunction

    assign out_free    = !m_valid_reg || m_ready;
    assign m_valid     = m_valid_reg;
    assign m_left_out  = out_reg[0];
    assign m_right_out = out_reg[1];
    assign q_pop       = (state_reg == S_IDLE) && !q_empty;

    always_comb begin
        if (cfg.thr < sbmsl_pkg::THR_MIN) begin
            g = sbmsl_pkg::THR_MIN;
        end else if (cfg.thr > sbmsl_pkg::THR_MAX) begin
            g = sbmsl_pkg::THR_MAX;
        end else begin
            g = cfg.thr;
        end
        kprod = g * sbmsl_pkg::KNEE_Q20;
        s_in[0] = q_item.s_l;
        s_in[1] = q_item.s_r;
        for (int c = 0; c < 2; c++) begin
            mag[c]  = s_in[c][24] ? 24'(-s_in[c]) : s_in[c][23:0];
            diff[c] = mag[c] - 24'(knee_reg);
            act[c]  = q_item.lim && !q_item.bypass && (mag[c] > 24'(knee_reg));
            sat[c]  = diff[c] >= {span_reg, 3'b000};
            idx[c]  = quo_reg[c][OW-1 -: IW];
            fr[c]   = FR'({quo_reg[c][OW-1-IW:0], {(IW-3){1'b0}}});
            lo[c]   = sbmsl_pkg::TANH_ROM[idx[c]];
            hi[c]   = sbmsl_pkg::TANH_ROM[(IW+1)'(idx[c]) + (IW+1)'(1)];
            dl[c]   = $signed({1'b0, hi[c]}) - $signed({1'b0, lo[c]});
            th[c]   = sat_reg[c] ? (FR+1)'(1 << FR)
                    : lo_reg[c] + (FR+1)'((prod_reg[c] + 43'sd524288) >>> FR);
            shaped[c] = 22'(knee_reg) + 22'((m2_reg[c] + 42'd524288) >> FR);
            val[c]  = s_reg[c][24] ? -$signed({4'b0, shaped[c]}) : $signed({4'b0, shaped[c]});
            if (bypass_reg) begin
                res[c] = s_reg[c][SW-1:0];
            end else if (active_reg[c]) begin
                res[c] = clip1(val[c]);
            end else begin
                res[c] = clip1(26'(s_reg[c]));
            end
        end
    end

    always_ff @(posedge aclk) begin
        knee_reg <= TW'((kprod + 41'd524288) >> FR);
        span_reg <= g - TW'((kprod + 41'd524288) >> FR);
        case (state_reg)
            S_IDLE: begin
                bypass_reg <= q_item.bypass;
                div_reg    <= {span_reg, 22'b0};
                cnt_reg    <= 5'(DIV_LAST);
                for (int c = 0; c < 2; c++) begin
                    s_reg[c]      <= s_in[c];
                    active_reg[c] <= act[c];
                    sat_reg[c]    <= sat[c];
                    rem_reg[c]    <= {diff[c], 20'b0};
                    quo_reg[c]    <= '0;
                end
            end
            S_DIV: begin
                div_reg <= div_reg >> 1;
                cnt_reg <= cnt_reg - 5'd1;
                for (int c = 0; c < 2; c++) begin
                    if (rem_reg[c] >= {1'b0, div_reg}) begin
                        rem_reg[c] <= rem_reg[c] - {1'b0, div_reg};
                        quo_reg[c] <= {quo_reg[c][OW-2:0], 1'b1};
                    end else begin
                        quo_reg[c] <= {quo_reg[c][OW-2:0], 1'b0};
                    end
                end
            end
            S_INTERP: begin
                for (int c = 0; c < 2; c++) begin
                    lo_reg[c]   <= lo[c];
                    prod_reg[c] <= dl[c] * $signed({1'b0, fr[c]});
                end
            end
            S_TH: begin
                for (int c = 0; c < 2; c++) begin
                    m2_reg[c] <= span_reg * th[c];
                end
            end
            default: begin
            end
        endcase
        if (state_reg == S_FIN && out_free) begin
            out_reg[0] <= res[0];
            out_reg[1] <= res[1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (!q_empty) begin
                        state_reg <= (act[0] || act[1]) ? S_DIV : S_FIN;
                    end
                end
                S_DIV: begin
                    if (cnt_reg == '0) begin
                        state_reg <= S_INTERP;
                    end
                end
                S_INTERP: begin
                    state_reg <= S_TH;
                end
                S_TH: begin
                    state_reg <= S_FIN;
                end
                S_FIN: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        state_reg   <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/core/stereo_bass_mono_soft_limiter.sv =====
// Stereo bass-mono folding and tanh soft-knee limiter on Q3.20 frames, one
// result transaction per input transaction. The front end takes a frame, does
// the one-pole lowpass multiply, then the fold, and feeds a 2-entry queue,
// taking no new frame until that push is done. With no sample above the
// knee the back end loads the output straight after taking a frame; else a
// restoring divider (one quotient bit per cycle, both channels side by side)
// forms the overdrive, then tanh table interpolation and rescale follow.
// Config writes go through the APB port and must be made only while no frame
// is in flight; writing one to bass_mono_enable or any value to
// bass_mono_coeff resets the lowpass state.
module stereo_bass_mono_soft_limiter (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [4:0]                            paddr,
    input  logic [31:0]                           pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [sbmsl_pkg::SAMPLE_W-1:0] s_left_sample,
    input  logic signed [sbmsl_pkg::SAMPLE_W-1:0] s_right_sample,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [sbmsl_pkg::SAMPLE_W-1:0] m_left_out,
    output logic signed [sbmsl_pkg::SAMPLE_W-1:0] m_right_out
);

    sbmsl_pkg::cfg_t  cfg_reg;
    logic             wr_en;
    logic [2:0]       wr_idx;
    logic             lp_clear;
    logic             q_push;
    logic             q_pop;
    logic             q_full;
    logic             q_empty;
    sbmsl_pkg::item_t q_in;
    sbmsl_pkg::item_t q_out;

    assign pready   = 1'b1;
    assign wr_en    = psel && penable && pwrite;
    assign wr_idx   = paddr[4:2];
    assign lp_clear = wr_en && ((wr_idx == sbmsl_pkg::REG_BASS && pwdata[0])
                             || wr_idx == sbmsl_pkg::REG_COEFF);

    always_comb begin
        case (wr_idx)
            sbmsl_pkg::REG_MASTER: prdata = {31'b0, cfg_reg.master};
            sbmsl_pkg::REG_BASS:   prdata = {31'b0, cfg_reg.bass};
            sbmsl_pkg::REG_LIM:    prdata = {31'b0, cfg_reg.lim};
            sbmsl_pkg::REG_THR:    prdata = {11'b0, cfg_reg.thr};
            sbmsl_pkg::REG_COEFF:  prdata = {12'b0, cfg_reg.coeff};
            default:               prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.master <= 1'b1;
            cfg_reg.bass   <= 1'b0;
            cfg_reg.lim    <= 1'b0;
            cfg_reg.thr    <= 21'd1048575;
            cfg_reg.coeff  <= sbmsl_pkg::COEFF_DEFAULT;
        end else if (wr_en) begin
            case (wr_idx)
                sbmsl_pkg::REG_MASTER: cfg_reg.master <= pwdata[0];
                sbmsl_pkg::REG_BASS:   cfg_reg.bass   <= pwdata[0];
                sbmsl_pkg::REG_LIM:    cfg_reg.lim    <= pwdata[0];
                sbmsl_pkg::REG_THR:    cfg_reg.thr    <= pwdata[sbmsl_pkg::THR_W-1:0];
                sbmsl_pkg::REG_COEFF:  cfg_reg.coeff  <= pwdata[sbmsl_pkg::COEFF_W-1:0];
                default: begin
                end
            endcase
        end
    end

    sbmsl_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg_reg),
        .lp_clear       (lp_clear),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_left_sample  (s_left_sample),
        .s_right_sample (s_right_sample),
        .q_push         (q_push),
        .q_item         (q_in),
        .q_full         (q_full)
    );

    sbmsl_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_item  (q_out),
        .empty     (q_empty)
    );

    sbmsl_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .q_empty     (q_empty),
        .q_item      (q_out),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_left_out  (m_left_out),
        .m_right_out (m_right_out)
    );

endmodule

// ===== dv/tb_stereo_bass_mono_soft_limiter.sv =====
`timescale 1ns / 100ps

module tb_stereo_bass_mono_soft_limiter;
    import sbmsl_pkg::*;

    localparam longint ONE     = 64'sd1 <<< 20;
    localparam longint SPAN8   = 64'sd8 <<< 20;
    localparam int     DEPTH   = 256;
    localparam int     N_DIR   = 16;
    localparam int     SETTLE  = 60;

    typedef struct {
        logic signed [SAMPLE_W-1:0] left;
        logic signed [SAMPLE_W-1:0] right;
    } frame_t;

    typedef struct {
        logic signed [SAMPLE_W-1:0] l;
        logic signed [SAMPLE_W-1:0] r;
        bit                         typed;
        logic signed [SAMPLE_W-1:0] el;
        logic signed [SAMPLE_W-1:0] er;
    } dir_row_t;

    logic                       aclk;
    logic                       aresetn;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [4:0]                 paddr;
    logic [31:0]                pwdata;
    logic [31:0]                prdata;
    logic                       pready;
    logic                       s_valid;
    logic                       s_ready;
    logic signed [SAMPLE_W-1:0] s_left_sample;
    logic signed [SAMPLE_W-1:0] s_right_sample;
    logic                       m_valid;
    logic                       m_ready;
    logic signed [SAMPLE_W-1:0] m_left_out;
    logic signed [SAMPLE_W-1:0] m_right_out;

    stereo_bass_mono_soft_limiter u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_left_sample  (s_left_sample),
        .s_right_sample (s_right_sample),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_left_out     (m_left_out),
        .m_right_out    (m_right_out)
    );

    // shadow of the block's registers and lowpass state
    bit          sh_master;
    bit          sh_bass;
    bit          sh_lim;
    longint      sh_thr;
    longint      sh_coeff;
    longint      lp_left;
    longint      lp_right;
    longint      tanh_tab [0:DEPTH];

    frame_t      expected_frames[$];
    int          mismatches;
    int          frames_seen;
    int          frames_sent;
    int          settings_used;
    bit          quiet;
    bit          hold_req;

    always #1 aclk = ~aclk;

    initial begin
        #5ms;
        $display("timeout");
        $display("CHECK FAILED");
        $finish;
    end

    function automatic void build_tanh_tab();
        longint one30;
        longint y;
        longint z;
        longint term;
        longint acc;
        longint t;
        longint den;
        one30 = 64'sd1 <<< 30;
        for (int i = 0; i <= DEPTH; i++) begin
            y    = ((64'sd16 <<< 30) * i) / DEPTH;
            z    = y >>> 5;
            term = one30;
            acc  = one30;
            for (int k = 1; k <= 12; k++) begin
                term = -((term * z) / (longint'(k) <<< 30));
                acc  = acc + term;
            end
            t = acc;
            for (int k = 0; k < 5; k++)
                t = (t * t + (one30 >>> 1)) >>> 30;
            den         = one30 + t;
            tanh_tab[i] = (((one30 - t) <<< 20) + den / 2) / den;
        end
    endfunction

    function automatic longint rnd(longint v, int sh);
        return (v + (64'sd1 <<< (sh - 1))) >>> sh;
    endfunction

    function automatic longint clamp8(longint v);
        return (v >= -SPAN8 && v <= SPAN8) ? v : 0;
    endfunction

    function automatic longint soft_knee(longint v);
        longint g;
        longint knee;
        longint span;
        longint mag;
        longint over;
        longint pos;
        longint idx;
        longint fr;
        longint th;
        longint shaped;
        g = sh_thr;
        if (g < THR_MIN) g = THR_MIN;
        if (g > THR_MAX) g = THR_MAX;
        knee = (g * KNEE_Q20 + (ONE >>> 1)) >>> 20;
        span = g - knee;
        mag  = v < 0 ? -v : v;
        if (mag > knee && span > 0) begin
            over = ((mag - knee) <<< 20) / span;
            if (over >= SPAN8) begin
                th = ONE;
            end else begin
                pos = (over * DEPTH) >>> 3;
                idx = pos >>> 20;
                fr  = pos & (ONE - 1);
                th  = tanh_tab[idx] + rnd((tanh_tab[idx+1] - tanh_tab[idx]) * fr, 20);
            end
            shaped = knee + rnd(span * th, 20);
            v = v < 0 ? -shaped : shaped;
        end
        return v;
    endfunction

    function automatic frame_t process_frame(frame_t f);
        longint v[2];
        longint a;
        longint xl;
        longint xr;
        longint pl;
        longint pr;
        longint mono;
        longint s;
        frame_t res;
        v[0] = longint'(f.left);
        v[1] = longint'(f.right);
        if (sh_master) begin
            if (sh_bass) begin
                a    = sh_coeff != 0 ? sh_coeff : longint'(COEFF_DEFAULT);
                xl   = clamp8(v[0]);
                xr   = clamp8(v[1]);
                pl   = clamp8(lp_left);
                pr   = clamp8(lp_right);
                pl   = clamp8(pl + rnd(a * (xl - pl), 20));
                pr   = clamp8(pr + rnd(a * (xr - pr), 20));
                mono = rnd(pl + pr, 1);
                v[0] = xl + (mono - pl);
                v[1] = xr + (mono - pr);
                lp_left  = pl;
                lp_right = pr;
            end
            for (int c = 0; c < 2; c++) begin
                s = clamp8(v[c]);
                if (sh_lim) s = soft_knee(s);
                if (s > ONE) s = ONE;
                else if (s < -ONE) s = -ONE;
                v[c] = s;
            end
        end
        res.left  = v[0][SAMPLE_W-1:0];
        res.right = v[1][SAMPLE_W-1:0];
        return res;
    endfunction

    task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_MASTER: sh_master = val[0];
            REG_BASS: begin
                sh_bass = val[0];
                if (val[0]) begin
                    lp_left  = 0;
                    lp_right = 0;
                end
            end
            REG_LIM:   sh_lim = val[0];
            REG_THR:   sh_thr = longint'(val[THR_W-1:0]);
            REG_COEFF: begin
                sh_coeff = longint'(val[COEFF_W-1:0]);
                lp_left  = 0;
                lp_right = 0;
            end
            default: ;
        endcase
    endtask

    task automatic set_all(bit mst, bit bas, bit lim, logic [31:0] thr, logic [31:0] cf);
        reg_write(REG_THR, thr);
        reg_write(REG_COEFF, cf);
        reg_write(REG_MASTER, {31'd0, mst});
        reg_write(REG_LIM, {31'd0, lim});
        reg_write(REG_BASS, {31'd0, bas});
        settings_used++;
    endtask

    // leaves s_valid high after acceptance; caller lowers it or sends again
    task automatic send_frame(input logic signed [SAMPLE_W-1:0] l,
                              input logic signed [SAMPLE_W-1:0] r,
                              input bit typed,
                              input logic signed [SAMPLE_W-1:0] el,
                              input logic signed [SAMPLE_W-1:0] er);
        int     gap;
        frame_t f;
        frame_t p;
        gap = 0;
        if (!quiet && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 9);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_left_sample  <= l;
        s_right_sample <= r;
        do @(posedge aclk); while (!s_ready);
        f.left  = l;
        f.right = r;
        p = process_frame(f);
        if (typed) begin
            p.left  = el;
            p.right = er;
        end
        expected_frames.push_back(p);
        frames_sent++;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (expected_frames.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    function automatic logic signed [SAMPLE_W-1:0] rand_sample(longint thr);
        int     kind;
        longint v;
        kind = $urandom_range(0, 9);
        case (kind)
            0, 1:    v = longint'($signed($urandom_range(0, 32'hFFFFFF) << 8)) >>> 8;
            2, 3, 4: v = longint'($urandom_range(0, 2 * ONE)) - ONE;
            5, 6:    v = thr - 30000 + longint'($urandom_range(0, 60000));
            7:       v = longint'($urandom_range(0, 4096)) - 2048;
            8:       v = $urandom_range(0, 1) ? 64'sd8388607 : -64'sd8388608;
            default: v = longint'($urandom_range(0, 3 * ONE)) - 3 * (ONE / 2);
        endcase
        if (kind == 5 || kind == 6) if ($urandom_range(0, 1)) v = -v;
        return v[SAMPLE_W-1:0];
    endfunction

    dir_row_t dir_tab [N_DIR] = '{
        '{24'sd0,        24'sd0,        1'b1, 24'sd0,        24'sd0},
        '{24'sd8388607,  -24'sd8388608, 1'b1, 24'sd1048576,  -24'sd1048576},
        '{24'sd1048576,  -24'sd1048576, 1'b1, 24'sd1048576,  -24'sd1048576},
        '{24'sd1048577,  -24'sd1048577, 1'b1, 24'sd1048576,  -24'sd1048576},
        '{24'sd1048575,  -24'sd1048575, 1'b1, 24'sd1048575,  -24'sd1048575},
        '{24'sd1,        -24'sd1,       1'b1, 24'sd1,        -24'sd1},
        '{24'sd964690,   24'sd964691,   1'b0, 24'sd0,        24'sd0},
        '{24'sd990000,   -24'sd1000000, 1'b0, 24'sd0,        24'sd0},
        '{24'sd8388607,  24'sd8388607,  1'b0, 24'sd0,        24'sd0},
        '{-24'sd8388608, -24'sd8388608, 1'b0, 24'sd0,        24'sd0},
        '{24'sd8388607,  -24'sd8388608, 1'b0, 24'sd0,        24'sd0},
        '{-24'sd8388608, 24'sd8388607,  1'b0, 24'sd0,        24'sd0},
        '{24'sd9000,     24'sd11000,    1'b0, 24'sd0,        24'sd0},
        '{24'sd2000000,  -24'sd3000000, 1'b0, 24'sd0,        24'sd0},
        '{24'sh5AA5A5,   24'shA55A5A,   1'b0, 24'sd0,        24'sd0},
        '{24'sd524288,   24'sd524289,   1'b0, 24'sd0,        24'sd0}
    };

    // result side: random backpressure, long hold-off on request
    initial begin
        int n;
        m_ready = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_req) begin
                m_ready <= 1'b0;
                n = 0;
                while (n < 300) begin
                    @(posedge aclk);
                    n++;
                end
                hold_req = 1'b0;
            end else if (quiet) begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge aclk);
                if (!quiet && !hold_req) begin
                    m_ready <= 1'b0;
                    repeat ($urandom_range(1, 9)) @(posedge aclk);
                end
            end
        end
    end

    always @(posedge aclk) begin
        frame_t e;
        if (aresetn && m_valid && m_ready) begin
            frames_seen++;
            if (expected_frames.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transaction L=%0d R=%0d",
                             m_left_out, m_right_out);
            end else begin
                e = expected_frames.pop_front();
                if (m_left_out !== e.left || m_right_out !== e.right) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch #%0d: exp L=%0d R=%0d got L=%0d R=%0d",
                                 frames_seen, e.left, e.right, m_left_out, m_right_out);
                end
            end
        end
    end

    initial begin
        int          n_items;
        bit          mst;
        bit          bas;
        bit          lim;
        logic [31:0] thr;
        logic [31:0] cf;
        longint      thr_use;
        aclk           = 1'b0;
        aresetn        = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        s_valid        = 1'b0;
        s_left_sample  = '0;
        s_right_sample = '0;
        quiet          = 1'b0;
        hold_req       = 1'b0;
        mismatches     = 0;
        frames_seen    = 0;
        frames_sent    = 0;
        settings_used  = 1;
        build_tanh_tab();
        sh_master = 1'b1;
        sh_bass   = 1'b0;
        sh_lim    = 1'b0;
        sh_thr    = 1048575;
        sh_coeff  = COEFF_DEFAULT;
        lp_left   = 0;
        lp_right  = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: plain hard clip, the first rows with results known by hand
        for (int i = 0; i < N_DIR; i++)
            send_frame(dir_tab[i].l, dir_tab[i].r, dir_tab[i].typed,
                       dir_tab[i].el, dir_tab[i].er);
        drain();

        // directed settings: limiter at both clamp ends, bass mono extremes, bypass
        for (int c = 0; c < 5; c++) begin
            case (c)
                0: set_all(1'b1, 1'b0, 1'b1, 32'd0, 32'd17775);
                1: set_all(1'b1, 1'b1, 1'b1, 32'h1FFFFF, 32'd0);
                2: set_all(1'b1, 1'b1, 1'b0, 32'd1048576, 32'hFFFFF);
                3: set_all(1'b0, 1'b1, 1'b1, 32'd10486, 32'd1);
                default: set_all(1'b1, 1'b1, 1'b1, 32'd500000, 32'd1);
            endcase
            for (int i = 0; i < N_DIR; i++)
                send_frame(dir_tab[i].l, dir_tab[i].r, 1'b0, '0, '0);
            drain();
        end

        for (int ph = 0; ph < 8; ph++) begin
            mst = $urandom_range(0, 7) != 0;
            bas = $urandom_range(0, 2) != 0;
            lim = $urandom_range(0, 2) != 0;
            case ($urandom_range(0, 4))
                0:       thr = 32'd10486;
                1:       thr = 32'd1048576;
                2:       thr = $urandom_range(0, 32'h1FFFFF);
                default: thr = $urandom_range(10486, 1048576);
            endcase
            case ($urandom_range(0, 4))
                0:       cf = 32'd1;
                1:       cf = 32'hFFFFF;
                2:       cf = 32'd0;
                default: cf = $urandom_range(1, 32'hFFFFF);
            endcase
            set_all(mst, bas, lim, thr, cf);
            thr_use = longint'(thr[THR_W-1:0]);
            if (thr_use < THR_MIN) thr_use = THR_MIN;
            if (thr_use > THR_MAX) thr_use = THR_MAX;
            quiet = (ph == 7);
            if (ph == 2) hold_req = 1'b1;
            n_items = 200;
            for (int i = 0; i < n_items; i++)
                send_frame(rand_sample(thr_use), rand_sample(thr_use), 1'b0, '0, '0);
            drain();
        end

        $display("%0d frames sent, %0d results checked, %0d register settings",
                 frames_sent, frames_seen, settings_used);
        $display("covered bypass, bass mono folding, soft knee limiting and hard clip");
        if (mismatches == 0 && expected_frames.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
